FILE: hdl/pfq_pkg.sv
`default_nettype none

package pfq_pkg;

	// Operation codes carried in the input tuser field.
	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_POLL = 2'd2;

	// Send status codes.
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_WAIT    = 2'd1;
	localparam logic [1:0] ST_EXPIRED = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;   // input beats may be taken this cycle
		logic do_meta;    // frame descriptor read data is valid
		logic do_drain;   // frame bytes are being streamed out
		logic do_zlen;    // emit the single beat of an empty frame
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;       // output register can take a beat
		logic drain_req;      // the offered beat would start a drain
		logic meta_len_zero;  // descriptor read shows an empty frame
		logic drain_done;     // final frame byte loaded into the output
	} stat_t;

endpackage

`default_nettype wire

FILE: hdl/pfq_ram.sv
`default_nettype none

module pfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pfq_ctrl.sv
`default_nettype none

module pfq_ctrl
	import pfq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	input  wire stat_t stat,
	output      cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_META  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_ZLEN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && stat.out_free && stat.drain_req) begin
					state_d = S_META;
				end
			end
			S_META: begin
				state_d = stat.meta_len_zero ? S_ZLEN : S_DRAIN;
			end
			S_DRAIN: begin
				if (stat.drain_done) begin
					state_d = S_IDLE;
				end
			end
			S_ZLEN: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.in_ready = (state_q == S_IDLE) && stat.out_free;
	assign cmd.do_meta  = (state_q == S_META);
	assign cmd.do_drain = (state_q == S_DRAIN);
	assign cmd.do_zlen  = (state_q == S_ZLEN);

endmodule

`default_nettype wire

FILE: hdl/pfq_datapath.sv
`default_nettype none

module pfq_datapath
	import pfq_pkg::*;
#(
	parameter int QUEUE_DEPTH     = 8,
	parameter int MAX_FRAME_BYTES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output      stat_t      stat,
	input  wire logic       s_tvalid,
	input  wire logic [1:0] func,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic [7:0] repeat_count,
	input  wire logic [7:0] radio_delay,
	input  wire logic [7:0] gap_ms,
	input  wire logic       m_tready,
	output      logic       m_tvalid,
	output      logic [7:0] out_byte,
	output      logic       byte_valid,
	output      logic       last,
	output      logic [7:0] out_repeat_count,
	output      logic [7:0] out_radio_delay,
	output      logic [3:0] queue_count,
	output      logic [1:0] status,
	output      logic       overflow
);

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int ADDR_W = $clog2(QUEUE_DEPTH * MAX_FRAME_BYTES);
	localparam int META_W = POS_W + 24;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
	localparam logic [POS_W-1:0]  POS_MAX   = POS_W'(MAX_FRAME_BYTES);
	localparam logic [ADDR_W-1:0] ROW_BYTES = ADDR_W'(MAX_FRAME_BYTES);

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_LAST) ? '0 : s + 1'b1;
	endfunction

	// Queue state.
	logic [SLOT_W-1:0] ws_q, ws_d, rs_q, rs_d, dslot_q;
	logic [CNT_W-1:0]  held_q, held_d;
	logic [POS_W-1:0]  fill_q, fill_d;
	logic [1:0]        st_q, st_d;
	logic [7:0]        gap_q, gap_d;

	// Drain state.
	logic [POS_W-1:0] len_q, issue_q;
	logic [7:0]       rep_q, dly_q;
	logic             pend_q, plast_q;

	// Output register.
	logic       ov_q;
	logic [7:0] ob_q, orep_q, odly_q;
	logic       obv_q, olast_q, oovf_q;
	logic [3:0] oqc_q;
	logic [1:0] ost_q;

	logic             in_fire, out_free, is_full, push_ovf;
	logic             store_we, meta_we, meta_re, store_re;
	logic [ADDR_W-1:0] store_waddr, store_raddr;
	logic [7:0]       store_rdata;
	logic [META_W-1:0] meta_wdata, meta_rdata;
	logic [POS_W-1:0] fill_inc, meta_len;
	logic [7:0]       meta_rep, meta_dly, meta_gap;
	logic             load_single, load_drain, load_zlen;

	assign out_free = !ov_q || m_tready;
	assign in_fire  = s_tvalid && cmd.in_ready;
	assign is_full  = (held_q >= CNT_FULL);
	assign fill_inc = fill_q + 1'b1;

	assign {meta_gap, meta_dly, meta_rep, meta_len} = meta_rdata;

	assign stat.out_free      = out_free;
	assign stat.drain_req     = (func == FUNC_POLL) && (st_q == ST_IDLE) && (held_q != '0);
	assign stat.meta_len_zero = (meta_len == '0);
	assign stat.drain_done    = load_drain && plast_q;

	assign load_single = in_fire && !stat.drain_req;
	assign load_drain  = cmd.do_drain && pend_q && out_free;
	assign load_zlen   = cmd.do_zlen && out_free;
	assign store_re    = cmd.do_drain && (issue_q < len_q) && (!pend_q || load_drain);
	assign meta_re     = in_fire && stat.drain_req;

	// Next queue state for an accepted input beat or a descriptor fetch.
	always_comb begin
		ws_d     = ws_q;
		rs_d     = rs_q;
		held_d   = held_q;
		fill_d   = fill_q;
		st_d     = st_q;
		gap_d    = gap_q;
		push_ovf = 1'b0;
		store_we = 1'b0;
		meta_we  = 1'b0;
		if (in_fire) begin
			unique case (func)
				FUNC_PUSH: begin
					if (is_full) begin
						push_ovf = 1'b1;
						if (last_byte) begin
							fill_d = '0;
						end
					end else begin
						if (fill_q < POS_MAX) begin
							store_we = 1'b1;
							fill_d   = fill_inc;
						end else begin
							push_ovf = 1'b1;
						end
						if (last_byte) begin
							meta_we = 1'b1;
							ws_d    = slot_next(ws_q);
							held_d  = held_q + 1'b1;
							fill_d  = '0;
						end
					end
				end
				FUNC_TICK: begin
					if (st_q == ST_WAIT) begin
						if (gap_q != '0) begin
							gap_d = gap_q - 1'b1;
						end
						if (gap_d == '0) begin
							st_d = ST_EXPIRED;
						end
					end
				end
				FUNC_POLL: begin
					if (stat.drain_req) begin
						rs_d   = slot_next(rs_q);
						held_d = held_q - 1'b1;
					end else if (st_q == ST_EXPIRED) begin
						st_d = ST_IDLE;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.do_meta && (meta_gap != '0)) begin
			gap_d = meta_gap;
			st_d  = ST_WAIT;
		end
	end

	// A push with the frame full keeps fill at the maximum, so the committed
	// length comes from the updated fill only when the byte was stored.
	assign meta_wdata  = {gap_ms, radio_delay, repeat_count, store_we ? fill_inc : fill_q};
	assign store_waddr = ADDR_W'(ws_q) * ROW_BYTES + ADDR_W'(fill_q);
	assign store_raddr = ADDR_W'(dslot_q) * ROW_BYTES + ADDR_W'(issue_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= '0;
			rs_q    <= '0;
			held_q  <= '0;
			fill_q  <= '0;
			st_q    <= ST_IDLE;
			gap_q   <= '0;
			issue_q <= '0;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			ws_q   <= ws_d;
			rs_q   <= rs_d;
			held_q <= held_d;
			fill_q <= fill_d;
			st_q   <= st_d;
			gap_q  <= gap_d;
			if (cmd.do_meta) begin
				issue_q <= '0;
				pend_q  <= 1'b0;
			end else if (store_re) begin
				issue_q <= issue_q + 1'b1;
				pend_q  <= 1'b1;
			end else if (load_drain) begin
				pend_q <= 1'b0;
			end
			if (load_single || load_drain || load_zlen) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (meta_re) begin
			dslot_q <= rs_q;
		end
		if (cmd.do_meta) begin
			len_q <= meta_len;
			rep_q <= meta_rep;
			dly_q <= meta_dly;
		end
		if (store_re) begin
			plast_q <= (issue_q == len_q - 1'b1);
		end
		if (load_single) begin
			ob_q    <= '0;
			obv_q   <= 1'b0;
			olast_q <= 1'b1;
			orep_q  <= '0;
			odly_q  <= '0;
			oqc_q   <= 4'(held_d);
			ost_q   <= st_d;
			oovf_q  <= push_ovf;
		end else if (load_drain || load_zlen) begin
			ob_q    <= load_drain ? store_rdata : 8'd0;
			obv_q   <= load_drain;
			olast_q <= load_drain ? plast_q : 1'b1;
			orep_q  <= rep_q;
			odly_q  <= dly_q;
			oqc_q   <= 4'(held_q);
			ost_q   <= st_q;
			oovf_q  <= 1'b0;
		end
	end

	pfq_ram #(
		.WIDTH(8),
		.DEPTH(QUEUE_DEPTH * MAX_FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (data_byte),
		.re    (store_re),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	pfq_ram #(
		.WIDTH(META_W),
		.DEPTH(QUEUE_DEPTH)
	) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (ws_q),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (rs_q),
		.rdata (meta_rdata)
	);

	assign m_tvalid         = ov_q;
	assign out_byte         = ob_q;
	assign byte_valid       = obv_q;
	assign last             = olast_q;
	assign out_repeat_count = orep_q;
	assign out_radio_delay  = odly_q;
	assign queue_count      = oqc_q;
	assign status           = ost_q;
	assign overflow         = oovf_q;

endmodule

`default_nettype wire

FILE: hdl/paced_frame_queue.sv
// Paced frame queue: a ring of QUEUE_DEPTH frames of up to MAX_FRAME_BYTES
// bytes each, built for a radio link that needs a quiet gap between frames.
// Every input beat carries an operation in tuser: push a frame byte (tlast
// commits the frame with its repeat count, radio delay and gap), a
// millisecond tick, or a service poll. Push, tick and a poll that drains
// nothing each answer with one status beat. A poll that finds the send
// status idle and a frame waiting drains the oldest frame: the frame
// descriptor is read first, then the first byte from the frame memory,
// and the frame then streams one byte beat per cycle while the output
// does not stall, with the input held off until the drain ends. An empty
// frame drains as a single beat with no valid byte. The frame's gap,
// when non-zero, puts the status into waiting; ticks count it down to
// expired, and the next poll returns it to idle without draining. Pushes into
// a full queue, and bytes beyond a full frame, are dropped and flagged in the
// overflow bit. An output register parts the two sides. While a beat waits
// there for tready the input is held off; the next input beat can be taken
// at the edge where the waiting beat leaves. The memories need no clearing
// after reset; only committed entries are ever read.

`default_nettype none

module paced_frame_queue
	import pfq_pkg::*;
#(
	parameter int QUEUE_DEPTH     = 8,
	parameter int MAX_FRAME_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [31:0] s_tdata,  // data_byte, repeat_count, radio_delay, gap_ms
	input  wire logic [1:0]  s_tuser,  // func
	input  wire logic        s_tlast,  // last_byte
	// Output stream.
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,  // out_byte, out_repeat_count, out_radio_delay,
	                                   // queue_count, status, overflow, one zero bit
	output      logic        m_tuser,  // byte_valid
	output      logic        m_tlast   // last
);

	cmd_t  cmd;
	stat_t stat;

	logic [7:0] out_byte, out_repeat_count, out_radio_delay;
	logic [3:0] queue_count;
	logic [1:0] status;
	logic       overflow;

	// The controller sequences descriptor fetch and byte streaming.
	pfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the queue pointers, gap timer, both memories and the
	// output register.
	pfq_datapath #(
		.QUEUE_DEPTH     (QUEUE_DEPTH),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.s_tvalid         (s_tvalid),
		.func             (s_tuser),
		.data_byte        (s_tdata[7:0]),
		.last_byte        (s_tlast),
		.repeat_count     (s_tdata[15:8]),
		.radio_delay      (s_tdata[23:16]),
		.gap_ms           (s_tdata[31:24]),
		.m_tready         (m_tready),
		.m_tvalid         (m_tvalid),
		.out_byte         (out_byte),
		.byte_valid       (m_tuser),
		.last             (m_tlast),
		.out_repeat_count (out_repeat_count),
		.out_radio_delay  (out_radio_delay),
		.queue_count      (queue_count),
		.status           (status),
		.overflow         (overflow)
	);

	assign s_tready = cmd.in_ready;
	assign m_tdata  = {1'b0, overflow, status, queue_count,
	                   out_radio_delay, out_repeat_count, out_byte};

endmodule

`default_nettype wire
